>>> rtl/core/cpf_pkg.sv
// Shared types and constants for the convex polyhedron point filter.
`default_nettype none

package cpf_pkg;

  // Field widths fixed by the word format
  localparam int DATA_W     = 32;
  localparam int SLOT_W     = 4;
  localparam int CNT_W      = 5;
  localparam int PROD_W     = 2 * DATA_W;
  // Three products plus the shifted offset, with headroom for the carries
  localparam int SUM_W      = PROD_W + 3;
  localparam int OFF_SHIFT  = 30;
  localparam int PLANES_DEF = 16;
  localparam int FIFO_DEPTH = 2;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TEST = 1'b1
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [SLOT_W-1:0] plane_slot;
    logic [DATA_W-1:0] normal_x;
    logic [DATA_W-1:0] normal_y;
    logic [DATA_W-1:0] normal_z;
    logic [DATA_W-1:0] plane_offset;
    logic [DATA_W-1:0] point_x;
    logic [DATA_W-1:0] point_y;
    logic [DATA_W-1:0] point_z;
    logic              last_point;
  } item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } seq_state_t;

  // Sequencer to plane evaluator
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } eval_ctl_t;

  // Plane evaluator to sequencer
  typedef struct packed {
    logic valid;
    logic outside;
  } eval_res_t;

endpackage

`default_nettype wire

>>> rtl/core/convex_polyhedron_point_filter_core.sv
// Top level of the convex polyhedron point filter: ports, config register, wiring.
//
// Usage:
//   The in_ channel carries one word per item. in_op selects a plane load or a
//   point test. A load writes normal and offset into table entry in_plane_slot
//   and gives no result; a test gives one out_ word with the inside flag and
//   the point passed through, with out_batch_end copied from in_last_point.
//   The cfg_ channel writes plane_count (cfg_data) and is always ready; write
//   it only while the block is idle.
//   A load retires while the sequencer stays idle. A test against n active
//   planes holds the back end while the sequencer reads one plane per cycle
//   from the table, the evaluation pipeline (table read, multiply, sum and
//   compare) drains and the result word is registered.
//   A two-word queue sits in front, so words are accepted while a test runs
//   or while a result waits. If out_ready stays low the result is held, the
//   back end stops at the next test and the queue fills, then in_ready drops.
//   Reset clears plane_count, the queue and all valid flags; the plane table
//   is not cleared and must be loaded before it is used.
`default_nettype none

module convex_polyhedron_point_filter_core #(
  parameter int MAX_PLANES = cpf_pkg::PLANES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Input words
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              in_op,
  input  wire logic [cpf_pkg::SLOT_W-1:0]        in_plane_slot,
  input  wire logic signed [cpf_pkg::DATA_W-1:0] in_normal_x,
  input  wire logic signed [cpf_pkg::DATA_W-1:0] in_normal_y,
  input  wire logic signed [cpf_pkg::DATA_W-1:0] in_normal_z,
  input  wire logic signed [cpf_pkg::DATA_W-1:0] in_plane_offset,
  input  wire logic signed [cpf_pkg::DATA_W-1:0] in_point_x,
  input  wire logic signed [cpf_pkg::DATA_W-1:0] in_point_y,
  input  wire logic signed [cpf_pkg::DATA_W-1:0] in_point_z,
  input  wire logic                              in_last_point,
  // Result words
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   out_inside_res,
  output logic signed [cpf_pkg::DATA_W-1:0]      out_kept_x,
  output logic signed [cpf_pkg::DATA_W-1:0]      out_kept_y,
  output logic signed [cpf_pkg::DATA_W-1:0]      out_kept_z,
  output logic                                   out_batch_end,
  // Config write
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [cpf_pkg::CNT_W-1:0]         cfg_data
);
  import cpf_pkg::*;

  localparam int IDX_W = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;

  item_t            in_item;
  item_t            deq_item;
  logic             deq_valid, deq_ready, deq_is_test;
  eval_ctl_t        ctl;
  eval_res_t        res;
  logic [IDX_W-1:0] wr_idx, rd_idx;
  logic [CNT_W-1:0] plane_count_r;
  logic [DATA_W-1:0] kept_x, kept_y, kept_z;

  // Pack the input word
  always_comb begin
    in_item.op           = op_t'(in_op);
    in_item.plane_slot   = in_plane_slot;
    in_item.normal_x     = in_normal_x;
    in_item.normal_y     = in_normal_y;
    in_item.normal_z     = in_normal_z;
    in_item.plane_offset = in_plane_offset;
    in_item.point_x      = in_point_x;
    in_item.point_y      = in_point_y;
    in_item.point_z      = in_point_z;
    in_item.last_point   = in_last_point;
  end

  // Plane count register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_count_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      plane_count_r <= cfg_data;
    end
  end

  cpf_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .deq_valid   (deq_valid),
    .deq_ready   (deq_ready),
    .deq_item    (deq_item),
    .deq_is_test (deq_is_test)
  );

  cpf_eval #(
    .MAX_PLANES (MAX_PLANES)
  ) u_eval (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .wr_idx (wr_idx),
    .wr_nx  (deq_item.normal_x),
    .wr_ny  (deq_item.normal_y),
    .wr_nz  (deq_item.normal_z),
    .wr_off (deq_item.plane_offset),
    .rd_idx (rd_idx),
    .pt_x   ($signed(deq_item.point_x)),
    .pt_y   ($signed(deq_item.point_y)),
    .pt_z   ($signed(deq_item.point_z)),
    .res    (res)
  );

  cpf_back #(
    .MAX_PLANES (MAX_PLANES)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .plane_count    (plane_count_r),
    .deq_valid      (deq_valid),
    .deq_ready      (deq_ready),
    .deq_item       (deq_item),
    .deq_is_test    (deq_is_test),
    .ctl            (ctl),
    .wr_idx         (wr_idx),
    .rd_idx         (rd_idx),
    .res            (res),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_inside_res (out_inside_res),
    .out_kept_x     (kept_x),
    .out_kept_y     (kept_y),
    .out_kept_z     (kept_z),
    .out_batch_end  (out_batch_end)
  );

  assign out_kept_x = $signed(kept_x);
  assign out_kept_y = $signed(kept_y);
  assign out_kept_z = $signed(kept_z);

endmodule

`default_nettype wire

>>> rtl/core/cpf_front.sv
// Input side: accepts words into a short queue and flags tests versus loads.
`default_nettype none

module cpf_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire cpf_pkg::item_t in_item,
  output logic                deq_valid,
  input  wire logic           deq_ready,
  output cpf_pkg::item_t      deq_item,
  output logic                deq_is_test
);
  import cpf_pkg::*;

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int QC_W  = $clog2(FIFO_DEPTH + 1);

  item_t            q_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QC_W-1:0]  cnt_r, cnt_nxt;
  logic             push, pop;

  // Handshake and head of queue
  assign in_ready    = (cnt_r != QC_W'(FIFO_DEPTH));
  assign deq_valid   = (cnt_r != '0);
  assign deq_item    = q_r[rd_ptr_r];
  assign deq_is_test = (q_r[rd_ptr_r].op == OP_TEST);
  assign push        = in_valid && in_ready;
  assign pop         = deq_valid && deq_ready;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/cpf_eval.sv
// Plane table and the three-stage plane evaluation pipeline.
`default_nettype none

module cpf_eval #(
  parameter  int MAX_PLANES = cpf_pkg::PLANES_DEF,
  localparam int IDX_W      = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire cpf_pkg::eval_ctl_t                ctl,
  input  wire logic [IDX_W-1:0]                  wr_idx,
  input  wire logic [cpf_pkg::DATA_W-1:0]        wr_nx,
  input  wire logic [cpf_pkg::DATA_W-1:0]        wr_ny,
  input  wire logic [cpf_pkg::DATA_W-1:0]        wr_nz,
  input  wire logic [cpf_pkg::DATA_W-1:0]        wr_off,
  input  wire logic [IDX_W-1:0]                  rd_idx,
  input  wire logic signed [cpf_pkg::DATA_W-1:0] pt_x,
  input  wire logic signed [cpf_pkg::DATA_W-1:0] pt_y,
  input  wire logic signed [cpf_pkg::DATA_W-1:0] pt_z,
  output cpf_pkg::eval_res_t                     res
);
  import cpf_pkg::*;

  logic [DATA_W-1:0] nx_mem  [MAX_PLANES];
  logic [DATA_W-1:0] ny_mem  [MAX_PLANES];
  logic [DATA_W-1:0] nz_mem  [MAX_PLANES];
  logic [DATA_W-1:0] off_mem [MAX_PLANES];

  logic [DATA_W-1:0]        nx_r, ny_r, nz_r, off_r;
  logic signed [PROD_W-1:0] px_r, py_r, pz_r;
  logic signed [DATA_W-1:0] d_r;
  logic signed [SUM_W-1:0]  sum_c;
  logic                     v1_r, v2_r, v3_r;
  logic                     outside_r;

  // Stage 1: table write, registered table read
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      nx_mem[wr_idx]  <= wr_nx;
      ny_mem[wr_idx]  <= wr_ny;
      nz_mem[wr_idx]  <= wr_nz;
      off_mem[wr_idx] <= wr_off;
    end
    if (ctl.rd_en) begin
      nx_r  <= nx_mem[rd_idx];
      ny_r  <= ny_mem[rd_idx];
      nz_r  <= nz_mem[rd_idx];
      off_r <= off_mem[rd_idx];
    end
  end

  // Stage 2: one multiplier per axis
  always_ff @(posedge clk) begin
    px_r <= $signed(nx_r) * pt_x;
    py_r <= $signed(ny_r) * pt_y;
    pz_r <= $signed(nz_r) * pt_z;
    d_r  <= $signed(off_r);
  end

  // Stage 3: exact sum in Q.46, strictly positive means outside
  assign sum_c = SUM_W'(px_r) + SUM_W'(py_r) + SUM_W'(pz_r)
               + (SUM_W'(d_r) <<< OFF_SHIFT);

  always_ff @(posedge clk) begin
    outside_r <= !sum_c[SUM_W-1] && (sum_c != '0);
  end

  // Valid bits follow the read through the stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= ctl.rd_en;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign res = '{valid: v3_r, outside: outside_r};

endmodule

`default_nettype wire

>>> rtl/core/cpf_back.sv
// Back end: test sequencer over the plane table and the result register.
`default_nettype none

module cpf_back #(
  parameter  int MAX_PLANES = cpf_pkg::PLANES_DEF,
  localparam int IDX_W      = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [cpf_pkg::CNT_W-1:0]  plane_count,
  input  wire logic                       deq_valid,
  output logic                            deq_ready,
  input  wire cpf_pkg::item_t             deq_item,
  input  wire logic                       deq_is_test,
  output cpf_pkg::eval_ctl_t              ctl,
  output logic [IDX_W-1:0]                wr_idx,
  output logic [IDX_W-1:0]                rd_idx,
  input  wire cpf_pkg::eval_res_t         res,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            out_inside_res,
  output logic [cpf_pkg::DATA_W-1:0]      out_kept_x,
  output logic [cpf_pkg::DATA_W-1:0]      out_kept_y,
  output logic [cpf_pkg::DATA_W-1:0]      out_kept_z,
  output logic                            out_batch_end
);
  import cpf_pkg::*;

  seq_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  n_c, n_last_c;
  logic [CNT_W-1:0]  iss_r, iss_nxt;
  logic [CNT_W-1:0]  rcv_r, rcv_nxt;
  logic              outside_r, outside_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              slot_ok;
  logic              ld_out;

  // Active plane count, saturated to the table depth
  assign n_c      = (int'(plane_count) > MAX_PLANES) ? CNT_W'(MAX_PLANES) : plane_count;
  assign n_last_c = n_c - 1'b1;
  assign slot_ok  = (int'(deq_item.plane_slot) < MAX_PLANES);
  assign wr_idx   = IDX_W'(deq_item.plane_slot);
  assign rd_idx   = IDX_W'(iss_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (deq_valid && deq_is_test) begin
          state_nxt = (n_c == '0) ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        if (iss_r == n_last_c) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (res.valid && (rcv_r == n_last_c)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (ld_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    deq_ready = 1'b0;
    ctl       = '0;
    ld_out    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (deq_valid && !deq_is_test) begin
          deq_ready  = 1'b1;
          ctl.wr_en  = slot_ok;
        end
      end
      ST_RUN: begin
        ctl.rd_en = 1'b1;
      end
      ST_DONE: begin
        ld_out    = !out_valid_r || out_ready;
        deq_ready = ld_out;
      end
      default: begin
        deq_ready = 1'b0;
      end
    endcase
  end

  // Issue and receive counters, outside accumulator, output valid
  always_comb begin
    iss_nxt       = iss_r;
    rcv_nxt       = rcv_r;
    outside_nxt   = outside_r;
    out_valid_nxt = out_valid_r;
    if (state_r == ST_IDLE) begin
      iss_nxt     = '0;
      rcv_nxt     = '0;
      outside_nxt = 1'b0;
    end else begin
      if (state_r == ST_RUN) begin
        iss_nxt = iss_r + 1'b1;
      end
      if (res.valid) begin
        rcv_nxt     = rcv_r + 1'b1;
        outside_nxt = outside_r | res.outside;
      end
    end
    if (ld_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      iss_r       <= '0;
      rcv_r       <= '0;
      outside_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iss_r       <= iss_nxt;
      rcv_r       <= rcv_nxt;
      outside_r   <= outside_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result word
  always_ff @(posedge clk) begin
    if (ld_out) begin
      out_inside_res <= !outside_r;
      out_kept_x     <= deq_item.point_x;
      out_kept_y     <= deq_item.point_y;
      out_kept_z     <= deq_item.point_z;
      out_batch_end  <= deq_item.last_point;
    end
  end

  assign out_valid = out_valid_r;

  // Plane results only come back while a test is running or draining
  a_res_in_test: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> (state_r == ST_RUN || state_r == ST_DRAIN))
    else $error("plane result outside a test");

  // Reads never go past the active plane count
  a_iss_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (iss_r < n_c))
    else $error("plane read beyond active count");

  // A result word is only built from a queued test
  a_ld_from_test: assert property (@(posedge clk) disable iff (!rst_n)
    ld_out |-> (deq_valid && deq_is_test))
    else $error("result loaded without a test at the queue head");

  // Loads are retired without leaving idle
  a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && deq_valid && !deq_is_test) |=> (state_r == ST_IDLE))
    else $error("load left the idle state");

endmodule

`default_nettype wire

>>> sim/cpf_point_filter_checker.sv
// Scoreboard for the point filter: tracks planes and count, predicts and checks each result word.
module cpf_point_filter_checker #(
  parameter int PLANES = cpf_pkg::PLANES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic                              in_op,
  input  logic [cpf_pkg::SLOT_W-1:0]        in_plane_slot,
  input  logic signed [cpf_pkg::DATA_W-1:0] in_normal_x,
  input  logic signed [cpf_pkg::DATA_W-1:0] in_normal_y,
  input  logic signed [cpf_pkg::DATA_W-1:0] in_normal_z,
  input  logic signed [cpf_pkg::DATA_W-1:0] in_plane_offset,
  input  logic signed [cpf_pkg::DATA_W-1:0] in_point_x,
  input  logic signed [cpf_pkg::DATA_W-1:0] in_point_y,
  input  logic signed [cpf_pkg::DATA_W-1:0] in_point_z,
  input  logic                              in_last_point,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic                              out_inside_res,
  input  logic signed [cpf_pkg::DATA_W-1:0] out_kept_x,
  input  logic signed [cpf_pkg::DATA_W-1:0] out_kept_y,
  input  logic signed [cpf_pkg::DATA_W-1:0] out_kept_z,
  input  logic                              out_batch_end,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [cpf_pkg::CNT_W-1:0]         cfg_data,
  output int                                mismatches,
  output int                                pending
);
  import cpf_pkg::*;

  // One predicted result word
  typedef struct packed {
    logic              keep;
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    logic [DATA_W-1:0] z;
    logic              last;
  } verdict_t;

  // Local copy of the plane table and the count register
  logic signed [DATA_W-1:0] nx_tab  [PLANES];
  logic signed [DATA_W-1:0] ny_tab  [PLANES];
  logic signed [DATA_W-1:0] nz_tab  [PLANES];
  logic signed [DATA_W-1:0] off_tab [PLANES];
  logic [CNT_W-1:0]         plane_count;
  verdict_t                 verdicts [$];
  int                       result_idx;

  // Exact half-space test: outside as soon as one plane gives a sum above zero
  function automatic logic point_inside(input logic signed [DATA_W-1:0] px,
                                        input logic signed [DATA_W-1:0] py,
                                        input logic signed [DATA_W-1:0] pz);
    logic signed [127:0] acc, ax, ay, az, ad, qx, qy, qz;
    int lim;
    lim = (plane_count > PLANES) ? PLANES : plane_count;
    qx = px;
    qy = py;
    qz = pz;
    point_inside = 1'b1;
    for (int i = 0; i < lim; i++) begin
      ax = nx_tab[i];
      ay = ny_tab[i];
      az = nz_tab[i];
      ad = off_tab[i];
      // offset is Q16.16, products are Q.46: align D by the normal's 30 bits
      acc = ax * qx + ay * qy + az * qz + (ad <<< OFF_SHIFT);
      if (acc > 0)
        point_inside = 1'b0;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[cpf_point_filter_checker] result %0d: %s", result_idx, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    verdict_t entry;
    if (!rst_n) begin
      plane_count = '0;
      verdicts.delete();
      mismatches  = 0;
      result_idx  = 0;
    end else begin
      // result side first: the oldest prediction belongs to this word
      if (out_valid && out_ready) begin
        if (verdicts.size() == 0) begin
          report_mismatch($sformatf("word with no prediction waiting (x %h)", out_kept_x));
        end else begin
          entry = verdicts.pop_front();
          if (out_inside_res !== entry.keep)
            report_mismatch($sformatf("inside_res got %b, expected %b",
                                      out_inside_res, entry.keep));
          if (out_kept_x !== entry.x)
            report_mismatch($sformatf("kept_x got %h, expected %h", out_kept_x, entry.x));
          if (out_kept_y !== entry.y)
            report_mismatch($sformatf("kept_y got %h, expected %h", out_kept_y, entry.y));
          if (out_kept_z !== entry.z)
            report_mismatch($sformatf("kept_z got %h, expected %h", out_kept_z, entry.z));
          if (out_batch_end !== entry.last)
            report_mismatch($sformatf("batch_end got %b, expected %b",
                                      out_batch_end, entry.last));
        end
        result_idx++;
      end

      if (cfg_valid && cfg_ready)
        plane_count = cfg_data;

      // input side: loads update the table, tests queue a prediction
      if (in_valid && in_ready) begin
        if (in_op == OP_LOAD) begin
          if (in_plane_slot < PLANES) begin
            nx_tab[in_plane_slot]  = in_normal_x;
            ny_tab[in_plane_slot]  = in_normal_y;
            nz_tab[in_plane_slot]  = in_normal_z;
            off_tab[in_plane_slot] = in_plane_offset;
          end
        end else begin
          entry.keep = point_inside(in_point_x, in_point_y, in_point_z);
          entry.x    = in_point_x;
          entry.y    = in_point_y;
          entry.z    = in_point_z;
          entry.last = in_last_point;
          verdicts.push_back(entry);
        end
      end
    end
    pending = verdicts.size();
  end

endmodule

>>> sim/convex_polyhedron_point_filter_core_tb.sv
// Testbench top for the point filter: clock, reset, word stimulus, receiver and verdict.
module convex_polyhedron_point_filter_core_tb;
  import cpf_pkg::*;

  localparam int CLK_PERIOD    = 20;
  localparam int RANDOM_ITEMS  = 1300;
  localparam int QUIET_AFTER   = 1100;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 500000;
  // Unit normal components in Q1.30: axis, face diagonal, corner diagonal
  localparam int ONE_Q30        = 1073741824;
  localparam int INV_SQRT2_Q30  = 759250125;
  localparam int INV_SQRT3_Q30  = 619925131;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic                     in_op;
  logic [SLOT_W-1:0]        in_plane_slot;
  logic signed [DATA_W-1:0] in_normal_x;
  logic signed [DATA_W-1:0] in_normal_y;
  logic signed [DATA_W-1:0] in_normal_z;
  logic signed [DATA_W-1:0] in_plane_offset;
  logic signed [DATA_W-1:0] in_point_x;
  logic signed [DATA_W-1:0] in_point_y;
  logic signed [DATA_W-1:0] in_point_z;
  logic                     in_last_point;
  logic                     out_valid;
  logic                     out_ready;
  logic                     out_inside_res;
  logic signed [DATA_W-1:0] out_kept_x;
  logic signed [DATA_W-1:0] out_kept_y;
  logic signed [DATA_W-1:0] out_kept_z;
  logic                     out_batch_end;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CNT_W-1:0]         cfg_data;

  int                       mismatches;
  int                       pending;
  int                       cycle_count;
  int                       half_size;
  bit                       quiet;
  bit                       steady;
  bit                       hold_req;
  logic [PLANES_DEF-1:0]    loaded;

  convex_polyhedron_point_filter_core uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_plane_slot   (in_plane_slot),
    .in_normal_x     (in_normal_x),
    .in_normal_y     (in_normal_y),
    .in_normal_z     (in_normal_z),
    .in_plane_offset (in_plane_offset),
    .in_point_x      (in_point_x),
    .in_point_y      (in_point_y),
    .in_point_z      (in_point_z),
    .in_last_point   (in_last_point),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_inside_res  (out_inside_res),
    .out_kept_x      (out_kept_x),
    .out_kept_y      (out_kept_y),
    .out_kept_z      (out_kept_z),
    .out_batch_end   (out_batch_end),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  cpf_point_filter_checker result_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_plane_slot   (in_plane_slot),
    .in_normal_x     (in_normal_x),
    .in_normal_y     (in_normal_y),
    .in_normal_z     (in_normal_z),
    .in_plane_offset (in_plane_offset),
    .in_point_x      (in_point_x),
    .in_point_y      (in_point_y),
    .in_point_z      (in_point_z),
    .in_last_point   (in_last_point),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_inside_res  (out_inside_res),
    .out_kept_x      (out_kept_x),
    .out_kept_y      (out_kept_y),
    .out_kept_z      (out_kept_z),
    .out_batch_end   (out_batch_end),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .pending         (pending)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Timeout
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[convex_polyhedron_point_filter_core] ERROR");
    $finish;
  end

  // Receiver: random stall bursts, one long hold on request, none in the quiet tail
  initial begin
    int span;
    out_ready = 1'b0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        for (int waited = 0; waited < HOLD_CYCLES; waited++) begin
          @(negedge clk);
          out_ready <= 1'b0;
        end
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        span = $urandom_range(1, 17);
        repeat (span) begin
          @(negedge clk);
          out_ready <= 1'b0;
        end
      end else begin
        span = $urandom_range(1, 24);
        repeat (span) begin
          @(negedge clk);
          out_ready <= 1'b1;
        end
      end
    end
  end

  // Plane load word; point fields are don't-care and get noise
  function automatic item_t load_word(input logic [SLOT_W-1:0] slot,
                                      input logic [DATA_W-1:0] ax, ay, az, d);
    item_t w;
    w.op           = OP_LOAD;
    w.plane_slot   = slot;
    w.normal_x     = ax;
    w.normal_y     = ay;
    w.normal_z     = az;
    w.plane_offset = d;
    w.point_x      = $urandom;
    w.point_y      = $urandom;
    w.point_z      = $urandom;
    w.last_point   = 1'($urandom_range(0, 1));
    return w;
  endfunction

  // Point test word; plane fields are don't-care and get noise
  function automatic item_t test_word(input logic [DATA_W-1:0] x, y, z,
                                      input logic last);
    item_t w;
    w.op           = OP_TEST;
    w.plane_slot   = SLOT_W'($urandom_range(0, PLANES_DEF - 1));
    w.normal_x     = $urandom;
    w.normal_y     = $urandom;
    w.normal_z     = $urandom;
    w.plane_offset = $urandom;
    w.point_x      = x;
    w.point_y      = y;
    w.point_z      = z;
    w.last_point   = last;
    return w;
  endfunction

  // Face of the current solid: one of 26 unit directions at distance half_size
  function automatic item_t shape_plane(input logic [SLOT_W-1:0] slot);
    int c [3];
    int k, mag;
    do begin
      k = 0;
      foreach (c[i]) begin
        c[i] = int'($urandom_range(0, 2)) - 1;
        if (c[i] != 0)
          k++;
      end
    end while (k == 0);
    mag = (k == 1) ? ONE_Q30 : (k == 2) ? INV_SQRT2_Q30 : INV_SQRT3_Q30;
    return load_word(slot, c[0] * mag, c[1] * mag, c[2] * mag, -half_size);
  endfunction

  // Coordinate around the solid, with some exactly on or just past an axis face
  function automatic int near_coord();
    int span;
    span = half_size + half_size / 4;
    case ($urandom_range(0, 7))
      0:       return half_size;
      1:       return half_size + 1;
      2:       return -half_size;
      default: return int'($urandom_range(0, 2 * span)) - span;
    endcase
  endfunction

  // Offer one word, with an optional gap first; returns once it is accepted
  task automatic send_word(input item_t w);
    if (!quiet && !steady && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 17)) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    @(negedge clk);
    in_valid        <= 1'b1;
    in_op           <= w.op;
    in_plane_slot   <= w.plane_slot;
    in_normal_x     <= w.normal_x;
    in_normal_y     <= w.normal_y;
    in_normal_z     <= w.normal_z;
    in_plane_offset <= w.plane_offset;
    in_point_x      <= w.point_x;
    in_point_y      <= w.point_y;
    in_point_z      <= w.point_z;
    in_last_point   <= w.last_point;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    if (w.op == OP_LOAD)
      loaded[w.plane_slot] = 1'b1;
  endtask

  // Stop offering, wait for every predicted word, then let trailing loads retire
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES)
      @(negedge clk);
  endtask

  task automatic write_count(input logic [CNT_W-1:0] value);
    @(negedge clk);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int sent, phase, m, active, r;
    bit fresh;
    logic [CNT_W-1:0] cnt;
    item_t w;

    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_op           = OP_LOAD;
    in_plane_slot   = '0;
    in_normal_x     = '0;
    in_normal_y     = '0;
    in_normal_z     = '0;
    in_plane_offset = '0;
    in_point_x      = '0;
    in_point_y      = '0;
    in_point_z      = '0;
    in_last_point   = 1'b0;
    cfg_valid       = 1'b0;
    cfg_data        = '0;
    quiet           = 1'b0;
    steady          = 1'b0;
    hold_req        = 1'b0;
    loaded          = '0;
    half_size       = 1 << 16;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: zero planes keeps every point, extreme coordinates
    send_word(test_word(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0));
    send_word(test_word(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1));
    // x <= 5.0 face, and a plane with the most negative normals and offset
    send_word(load_word(4'd0, ONE_Q30, 0, 0, -(5 << 16)));
    send_word(load_word(4'd1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    settle();
    write_count(5'd1);
    // on the face is inside, one LSB past it is outside
    send_word(test_word(5 << 16, 0, 0, 1'b0));
    send_word(test_word((5 << 16) + 1, 0, 0, 1'b0));
    send_word(test_word(-(1000 << 16), 7, -7, 1'b1));
    settle();
    write_count(5'd2);
    send_word(test_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0));
    send_word(test_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
    send_word(test_word(0, 0, 0, 1'b1));
    // overwrite with the most positive normals and offset
    send_word(load_word(4'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_word(test_word(0, 0, 0, 1'b0));
    send_word(test_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1));
    send_word(load_word(4'd15, 0, -ONE_Q30, 0, 32'h7FFF_FFFF));

    // Random phases: a count, a fresh solid, then mostly points around it
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      quiet  = (sent >= QUIET_AFTER);
      steady = ($urandom_range(0, 3) == 0);
      case (phase)
        0: cnt = '1;
        1: cnt = CNT_W'(PLANES_DEF + 1);
        2: cnt = CNT_W'(PLANES_DEF);
        3: cnt = '0;
        default:
          case ($urandom_range(0, 5))
            0:       cnt = '0;
            1:       cnt = 5'd1;
            2:       cnt = CNT_W'(PLANES_DEF);
            3:       cnt = CNT_W'($urandom_range(PLANES_DEF + 1, 31));
            default: cnt = CNT_W'($urandom_range(1, PLANES_DEF));
          endcase
      endcase
      write_count(cnt);
      active    = (cnt > PLANES_DEF) ? PLANES_DEF : cnt;
      half_size = $urandom_range(1 << 16, 200000000);
      fresh     = ($urandom_range(0, 9) < 7);
      // every active slot must hold a plane before a point reads it
      for (int s = 0; s < active; s++)
        if (fresh || !loaded[s]) begin
          send_word(shape_plane(SLOT_W'(s)));
          sent++;
        end
      // long receiver hold while words keep coming, so the input stalls
      if (phase == 2)
        hold_req = 1'b1;
      m = $urandom_range(30, 120);
      repeat (m) begin
        r = $urandom_range(0, 99);
        if (r < 5)
          w = shape_plane(SLOT_W'($urandom_range(0, PLANES_DEF - 1)));
        else if (r < 8)
          w = load_word(SLOT_W'($urandom_range(0, PLANES_DEF - 1)), $urandom, $urandom,
                        $urandom, $urandom);
        else if (r < 23)
          w = test_word($urandom, $urandom, $urandom, $urandom_range(0, 7) == 0);
        else
          w = test_word(near_coord(), near_coord(), near_coord(),
                        $urandom_range(0, 7) == 0);
        send_word(w);
        sent++;
      end
      phase++;
    end

    settle();
    if (mismatches == 0)
      $display("[convex_polyhedron_point_filter_core] OK");
    else
      $display("[convex_polyhedron_point_filter_core] ERROR");
    $finish;
  end

endmodule

>>> convex_polyhedron_point_filter_core.f
rtl/core/cpf_pkg.sv
rtl/core/cpf_front.sv
rtl/core/cpf_eval.sv
rtl/core/cpf_back.sv
rtl/core/convex_polyhedron_point_filter_core.sv
sim/cpf_point_filter_checker.sv
sim/convex_polyhedron_point_filter_core_tb.sv
